### rtl/etd_pkg.sv
// Shared widths, register indices, reset values and helpers for the escape-time dwell block.
package etd_pkg;

  localparam int CFG_W       = 32;
  localparam int LIMIT_W     = 16;
  localparam int PIX_W       = 6;
  localparam int DWELL_W     = 16;
  localparam int CFG_IDX_W   = 3;

  localparam int IMAGE_ROWS_DEF = 64;
  localparam int FRAC_BITS_DEF  = 28;

  localparam logic [CFG_IDX_W-1:0] REG_CORNER_REAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_IMAG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_REAL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_IMAG   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT  = 3'd4;

  localparam logic [CFG_W-1:0]   CORNER_REAL_RST = 32'hE000_0000;
  localparam logic [CFG_W-1:0]   CORNER_IMAG_RST = 32'hE000_0000;
  localparam logic [CFG_W-1:0]   STEP_REAL_RST   = 32'h0100_0000;
  localparam logic [CFG_W-1:0]   STEP_IMAG_RST   = 32'h0100_0000;
  localparam logic [LIMIT_W-1:0] ITER_LIMIT_RST  = 16'd100;

  // signed width of (rows - 1 - row) for any 6-bit row
  function automatic int rmul_width(input int rows);
    return $clog2(rows) + PIX_W + 2;
  endfunction

  // width of the exact point coordinate
  function automatic int coord_width(input int rows, input int frac);
    int a;
    int b;
    a = CFG_W + 1 + rmul_width(rows);
    b = frac + 5;
    return (a > b) ? a : b;
  endfunction

endpackage

### rtl/etd_map.sv
// Pixel to complex-plane mapping, registered on input acceptance.
module etd_map import etd_pkg::*; #(
  parameter int IMAGE_ROWS = IMAGE_ROWS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    load,
  input  logic [PIX_W-1:0]        pixel_col,
  input  logic [PIX_W-1:0]        pixel_row,
  input  logic signed [CFG_W-1:0] corner_real,
  input  logic signed [CFG_W-1:0] corner_imag,
  input  logic signed [CFG_W-1:0] step_real,
  input  logic signed [CFG_W-1:0] step_imag,
  output logic signed [coord_width(IMAGE_ROWS, FRAC_BITS)-1:0] c_re_r,
  output logic signed [coord_width(IMAGE_ROWS, FRAC_BITS)-1:0] c_im_r
);

  localparam int RMUL_W = rmul_width(IMAGE_ROWS);
  localparam int CW     = coord_width(IMAGE_ROWS, FRAC_BITS);

  logic signed [RMUL_W-1:0] rmul;
  logic signed [PIX_W:0]    col_s;
  logic signed [CW-1:0]     c_re_nxt;
  logic signed [CW-1:0]     c_im_nxt;

  assign col_s    = $signed({1'b0, pixel_col});
  assign rmul     = RMUL_W'(IMAGE_ROWS - 1) - RMUL_W'(pixel_row);
  assign c_re_nxt = CW'(corner_real) + CW'(col_s) * CW'(step_real);
  assign c_im_nxt = CW'(corner_imag) + CW'(rmul) * CW'(step_imag);

  always_ff @(posedge clk) begin
    if (load) begin
      c_re_r <= c_re_nxt;
      c_im_r <= c_im_nxt;
    end
  end

endmodule

### rtl/etd_csq.sv
// Shared complex squaring unit: registered re^2, im^2 and 2*re*im, truncated toward zero.
module etd_csq import etd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [FRAC_BITS+1:0] z_re,
  input  logic signed [FRAC_BITS+1:0] z_im,
  output logic [FRAC_BITS+1:0]        sq_re_r,
  output logic [FRAC_BITS+1:0]        sq_im_r,
  output logic signed [FRAC_BITS+3:0] cross_r
);

  localparam int MW = FRAC_BITS + 1;
  localparam int PW = 2 * MW;
  localparam int XW = FRAC_BITS + 3;

  logic [MW-1:0]              mag_re;
  logic [MW-1:0]              mag_im;
  logic [PW-1:0]              p_rr;
  logic [PW-1:0]              p_ii;
  logic [PW-1:0]              p_ri;
  logic [XW-1:0]              cross_mag;
  logic signed [FRAC_BITS+3:0] cross_ext;
  logic                       neg;

  assign mag_re    = z_re[FRAC_BITS+1] ? MW'(-z_re) : MW'(z_re);
  assign mag_im    = z_im[FRAC_BITS+1] ? MW'(-z_im) : MW'(z_im);
  assign neg       = z_re[FRAC_BITS+1] ^ z_im[FRAC_BITS+1];
  assign p_rr      = PW'(mag_re) * PW'(mag_re);
  assign p_ii      = PW'(mag_im) * PW'(mag_im);
  assign p_ri      = PW'(mag_re) * PW'(mag_im);
  assign cross_mag = p_ri[FRAC_BITS-1 +: XW];
  assign cross_ext = $signed({1'b0, cross_mag});

  always_ff @(posedge clk) begin
    if (en) begin
      sq_re_r <= p_rr[FRAC_BITS +: FRAC_BITS+2];
      sq_im_r <= p_ii[FRAC_BITS +: FRAC_BITS+2];
      cross_r <= neg ? -cross_ext : cross_ext;
    end
  end

endmodule

### rtl/escape_time_dwell.sv
// Escape-time dwell engine: top level with configuration registers and iteration sequencer.
// One pixel is taken at a time; in_ready is high only while the engine is idle. After
// acceptance the point is mapped into registers and range-checked in S_CHECK; a point outside
// the |re|,|im| < 2 square finishes at once with dwell 1. Each further step runs on the
// single complex squaring unit through S_MUL (products registered) and S_ADD (sums and
// escape tests); out_valid rises when the new point leaves the square, or when the
// iteration stops on |z|^2 or the limit, and then holds its result until out_ready.
// Configuration must be written through cfg_wr_en/cfg_index/cfg_wr_data only while idle;
// the block itself does not enforce this. Corner and step values are signed fixed point with
// FRAC_BITS fraction bits.
module escape_time_dwell import etd_pkg::*; #(
  parameter int IMAGE_ROWS = IMAGE_ROWS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     in_pixel_col,
  input  logic [PIX_W-1:0]     in_pixel_row,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DWELL_W-1:0]   out_dwell,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wr_data
);

  localparam int CW = coord_width(IMAGE_ROWS, FRAC_BITS);
  localparam int ZW = FRAC_BITS + 2;
  localparam int WA = FRAC_BITS + 5;
  localparam int LW = FRAC_BITS + 3;

  localparam logic signed [CW-1:0] TWO_C     = CW'(2) <<< FRAC_BITS;
  localparam logic signed [CW-1:0] NEG_TWO_C = -TWO_C;
  localparam logic signed [WA-1:0] TWO_A     = WA'(2) <<< FRAC_BITS;
  localparam logic signed [WA-1:0] NEG_TWO_A = -TWO_A;
  localparam logic [LW-1:0]        FOUR_L    = LW'(4) << FRAC_BITS;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_MUL   = 5'b00100,
    S_ADD   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [CFG_W-1:0] corner_real_r;
  logic signed [CFG_W-1:0] corner_imag_r;
  logic signed [CFG_W-1:0] step_real_r;
  logic signed [CFG_W-1:0] step_imag_r;
  logic [LIMIT_W-1:0]      limit_r;

  logic [DWELL_W-1:0]      count_r, count_nxt;
  logic signed [ZW-1:0]    zr_r, zr_nxt;
  logic signed [ZW-1:0]    zi_r, zi_nxt;

  logic signed [CW-1:0]    c_re_r;
  logic signed [CW-1:0]    c_im_r;
  logic [ZW-1:0]           sq_re_r;
  logic [ZW-1:0]           sq_im_r;
  logic signed [FRAC_BITS+3:0] cross_r;

  logic signed [WA-1:0]    c_re_a;
  logic signed [WA-1:0]    c_im_a;
  logic signed [WA-1:0]    sq_re_a;
  logic signed [WA-1:0]    sq_im_a;
  logic signed [WA-1:0]    cross_a;
  logic signed [WA-1:0]    zr_new;
  logic signed [WA-1:0]    zi_new;
  logic [LW-1:0]           len;
  logic                    c_out;
  logic                    z_esc;
  logic                    len_esc;
  logic                    in_fire;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (state_r == S_DONE);
  assign out_dwell = count_r;

  etd_map #(
    .IMAGE_ROWS (IMAGE_ROWS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_map (
    .clk         (clk),
    .load        (in_fire),
    .pixel_col   (in_pixel_col),
    .pixel_row   (in_pixel_row),
    .corner_real (corner_real_r),
    .corner_imag (corner_imag_r),
    .step_real   (step_real_r),
    .step_imag   (step_imag_r),
    .c_re_r      (c_re_r),
    .c_im_r      (c_im_r)
  );

  etd_csq #(
    .FRAC_BITS (FRAC_BITS)
  ) u_csq (
    .clk     (clk),
    .en      (state_r == S_MUL),
    .z_re    (zr_r),
    .z_im    (zi_r),
    .sq_re_r (sq_re_r),
    .sq_im_r (sq_im_r),
    .cross_r (cross_r)
  );

  assign c_out = (c_re_r >= TWO_C) || (c_re_r <= NEG_TWO_C) ||
                 (c_im_r >= TWO_C) || (c_im_r <= NEG_TWO_C);

  assign c_re_a  = c_re_r[WA-1:0];
  assign c_im_a  = c_im_r[WA-1:0];
  assign sq_re_a = WA'(sq_re_r);
  assign sq_im_a = WA'(sq_im_r);
  assign cross_a = WA'(cross_r);
  assign zr_new  = sq_re_a - sq_im_a + c_re_a;
  assign zi_new  = cross_a + c_im_a;
  assign z_esc   = (zr_new >= TWO_A) || (zr_new <= NEG_TWO_A) ||
                   (zi_new >= TWO_A) || (zi_new <= NEG_TWO_A);
  assign len     = LW'(sq_re_r) + LW'(sq_im_r);
  assign len_esc = (len >= FOUR_L);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    zr_nxt    = zr_r;
    zi_nxt    = zi_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CHECK;
          count_nxt = '0;
        end
      end
      S_CHECK: begin
        if (c_out) begin
          count_nxt = DWELL_W'(1);
          state_nxt = S_DONE;
        end else begin
          zr_nxt    = c_re_r[ZW-1:0];
          zi_nxt    = c_im_r[ZW-1:0];
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if ((count_r != '0) && (len_esc || (count_r >= limit_r))) begin
          state_nxt = S_DONE;
        end else begin
          count_nxt = DWELL_W'(count_r + 1'b1);
          zr_nxt    = zr_new[ZW-1:0];
          zi_nxt    = zi_new[ZW-1:0];
          state_nxt = z_esc ? S_DONE : S_MUL;
        end
      end
      S_DONE: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    zr_r <= zr_nxt;
    zi_r <= zi_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_real_r <= CORNER_REAL_RST;
      corner_imag_r <= CORNER_IMAG_RST;
      step_real_r   <= STEP_REAL_RST;
      step_imag_r   <= STEP_IMAG_RST;
      limit_r       <= ITER_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CORNER_REAL: corner_real_r <= cfg_wr_data;
        REG_CORNER_IMAG: corner_imag_r <= cfg_wr_data;
        REG_STEP_REAL:   step_real_r   <= cfg_wr_data;
        REG_STEP_IMAG:   step_imag_r   <= cfg_wr_data;
        REG_ITER_LIMIT:  limit_r       <= cfg_wr_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/etd_chk.sv
// Port-level checker for the escape-time dwell engine, bound to the top level.
module etd_chk import etd_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DWELL_W-1:0] out_dwell
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("engine still ready after taking a transaction");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dwell))
    else $error("stalled result changed or dropped");

  a_dwell_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_dwell != '0)
    else $error("dwell of zero presented");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a result is pending");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready && !out_valid)
    else $error("engine did not return to idle after result transaction");

endmodule

bind escape_time_dwell etd_chk u_etd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_dwell (out_dwell)
);

### tb/sv/tb_escape_time_dwell.sv
// Self-checking testbench for escape_time_dwell: predicts each pixel's dwell and checks results.
module tb_escape_time_dwell;
  import etd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int    FRAC      = FRAC_BITS_DEF;
  localparam longint FX_TWO   = 64'sd2 << FRAC;
  localparam longint FX_FOUR  = 64'sd4 << FRAC;
  localparam int    QUIET_MAX = 400000;
  localparam int    LONG_HOLD = 300;

  typedef struct packed {
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0]   col;
    logic [PIX_W-1:0]   row;
    logic [DWELL_W-1:0] dwell;
  } dwell_exp_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_pixel_col = '0;
  logic [PIX_W-1:0]     in_pixel_row = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [DWELL_W-1:0]   out_dwell;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wr_data = '0;

  logic signed [CFG_W-1:0] view_re;
  logic signed [CFG_W-1:0] view_im;
  logic signed [CFG_W-1:0] pitch_re;
  logic signed [CFG_W-1:0] pitch_im;
  logic [LIMIT_W-1:0]      max_iters;

  pixel_t     pixel_q[$];
  dwell_exp_t dwell_q[$];
  dwell_exp_t got;
  int         queued_cnt = 0;
  int         accepted_cnt = 0;
  int         errors = 0;
  int         quiet_cycles = 0;
  bit         in_accepted = 1'b0;
  bit         idling_on = 1'b1;
  int         send_gap = 0;
  int         stall_left = 0;
  int         hold_left = 0;
  int         hold_req = 0;
  int         hold_seen = 0;

  escape_time_dwell dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_pixel_col(in_pixel_col),
    .in_pixel_row(in_pixel_row),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_dwell   (out_dwell),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] mag(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // product shifted down, truncated toward zero
  function automatic longint trunc_mul(input longint a, input longint b, input int sh);
    logic [127:0] p;
    logic [63:0]  r;
    p = {64'd0, mag(a)} * {64'd0, mag(b)};
    p = p >> sh;
    r = p[63:0];
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic [DWELL_W-1:0] escape_dwell(input logic [PIX_W-1:0] col,
                                                      input logic [PIX_W-1:0] row);
    longint cr;
    longint ci;
    longint zr;
    longint zi;
    longint sq_r;
    longint sq_i;
    longint xprod;
    longint col_l;
    longint rmul;
    longint step_r;
    longint step_i;
    int     n;
    bit     stop;
    col_l  = longint'(col);
    rmul   = longint'(IMAGE_ROWS_DEF - 1) - longint'(row);
    step_r = pitch_re;
    step_i = pitch_im;
    cr     = view_re;
    ci     = view_im;
    cr     = cr + col_l * step_r;
    ci     = ci + rmul * step_i;
    if (mag(cr) >= 64'(FX_TWO) || mag(ci) >= 64'(FX_TWO)) return DWELL_W'(1);
    zr   = cr;
    zi   = ci;
    n    = 0;
    stop = 1'b0;
    while (!stop) begin
      sq_r  = trunc_mul(zr, zr, FRAC);
      sq_i  = trunc_mul(zi, zi, FRAC);
      xprod = trunc_mul(zr, zi, FRAC - 1);
      zr    = sq_r - sq_i + cr;
      zi    = xprod + ci;
      n++;
      if (mag(zr) >= 64'(FX_TWO) || mag(zi) >= 64'(FX_TWO)) stop = 1'b1;
      else if (trunc_mul(zr, zr, FRAC) + trunc_mul(zi, zi, FRAC) >= FX_FOUR) stop = 1'b1;
      else if (n >= int'(max_iters)) stop = 1'b1;
    end
    return DWELL_W'(n);
  endfunction

  // sender: advance to the next pixel once the current transaction is taken
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_accepted)) begin
      in_accepted = 1'b0;
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pixel_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(1, 10) - 1;
        in_valid <= 1'b0;
      end else begin
        in_valid     <= 1'b1;
        in_pixel_col <= pixel_q[0].col;
        in_pixel_row <= pixel_q[0].row;
        void'(pixel_q.pop_front());
      end
    end
  end

  // receiver: random stalls plus an occasional long hold
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      got.col   = in_pixel_col;
      got.row   = in_pixel_row;
      got.dwell = escape_dwell(in_pixel_col, in_pixel_row);
      dwell_q.push_back(got);
      accepted_cnt++;
      in_accepted = 1'b1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (dwell_q.size() == 0) begin
        $display("%0t: unexpected dwell transaction, expected none, actual %0d",
                 $time, out_dwell);
        errors++;
      end else begin
        got = dwell_q.pop_front();
        if (out_dwell !== got.dwell) begin
          $display("%0t: dwell mismatch at col %0d row %0d: expected %0d, actual %0d",
                   $time, got.col, got.row, got.dwell, out_dwell);
          errors++;
        end
      end
    end
    if (!rst_n || cfg_wr_en || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_MAX) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    case (idx)
      REG_CORNER_REAL: view_re   = val;
      REG_CORNER_IMAG: view_im   = val;
      REG_STEP_REAL:   pitch_re  = val;
      REG_STEP_IMAG:   pitch_im  = val;
      REG_ITER_LIMIT:  max_iters = val[LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic queue_pixel(input int col, input int row);
    pixel_t p;
    p.col = PIX_W'(col);
    p.row = PIX_W'(row);
    pixel_q.push_back(p);
    queued_cnt++;
  endtask

  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || dwell_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    longint base;
    longint span;
    longint stp;
    int     ph;
    view_re   = CORNER_REAL_RST;
    view_im   = CORNER_IMAG_RST;
    pitch_re  = STEP_REAL_RST;
    pitch_im  = STEP_IMAG_RST;
    max_iters = ITER_LIMIT_RST;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset view: edges, origin, interior and points near the boundary
    queue_pixel(0, 0);
    queue_pixel(63, 63);
    queue_pixel(63, 0);
    queue_pixel(0, 63);
    queue_pixel(32, 31);
    queue_pixel(24, 39);
    queue_pixel(31, 0);
    queue_pixel(20, 31);
    queue_pixel(4, 31);
    queue_pixel(36, 31);
    wait_drained();

    write_reg(REG_ITER_LIMIT, '0);
    queue_pixel(32, 31);
    queue_pixel(24, 39);
    wait_drained();

    write_reg(REG_ITER_LIMIT, CFG_W'(1));
    queue_pixel(32, 31);
    queue_pixel(0, 0);
    wait_drained();

    write_reg(REG_CORNER_REAL, 32'h8000_0000);
    write_reg(REG_CORNER_IMAG, 32'h7FFF_FFFF);
    write_reg(REG_STEP_REAL, 32'h7FFF_FFFF);
    write_reg(REG_STEP_IMAG, 32'h8000_0000);
    write_reg(REG_ITER_LIMIT, CFG_W'(16'hFFFF));
    queue_pixel(0, 0);
    queue_pixel(63, 63);
    wait_drained();

    // origin never escapes: runs to the full limit
    write_reg(REG_CORNER_REAL, '0);
    write_reg(REG_CORNER_IMAG, '0);
    write_reg(REG_STEP_REAL, '0);
    write_reg(REG_STEP_IMAG, '0);
    queue_pixel(5, 9);
    wait_drained();

    for (ph = 0; ph < 12; ph++) begin
      if (ph >= 10) idling_on = 1'b0;
      span = $urandom_range(32'h0040_0000, 32'h4000_0000);
      base = longint'($urandom_range(0, 805306368)) - 64'sd603979776;
      write_reg(REG_CORNER_REAL, 32'(base));
      base = longint'($urandom_range(0, 402653184)) - 64'sd402653184;
      write_reg(REG_CORNER_IMAG, 32'(base));
      stp = span >>> 6;
      if ($urandom_range(0, 5) == 0) stp = -stp;
      write_reg(REG_STEP_REAL, 32'(stp));
      stp = (span >>> 6) + longint'($urandom_range(0, 4096));
      if ($urandom_range(0, 5) == 0) stp = -stp;
      write_reg(REG_STEP_IMAG, 32'(stp));
      if (ph % 4 == 3)
        write_reg(REG_ITER_LIMIT, CFG_W'($urandom_range(300, 600)));
      else
        write_reg(REG_ITER_LIMIT, CFG_W'($urandom_range(1, 256)));
      if (ph == 1) hold_req++;
      repeat (80) queue_pixel($urandom_range(0, 63), $urandom_range(0, 63));
      wait_drained();

      if (ph == 5) begin
        write_reg(REG_CORNER_REAL, $urandom());
        write_reg(REG_CORNER_IMAG, $urandom());
        write_reg(REG_STEP_REAL, $urandom());
        write_reg(REG_STEP_IMAG, $urandom());
        write_reg(REG_ITER_LIMIT, CFG_W'($urandom_range(1, 300)));
        repeat (60) queue_pixel($urandom_range(0, 63), $urandom_range(0, 63));
        wait_drained();
      end
    end

    repeat (50) @(negedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
